[hdl/ilp_pkg.sv]
package ilp_pkg;

    localparam int MAX_CHARS   = 4096;
    localparam int VALUE_WIDTH = 64;
    localparam int IDX_W       = $clog2(MAX_CHARS + 1);
    localparam int OFF_W       = 13;
    localparam int OUT_W       = 64;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_1     = 8'd49;
    localparam logic [7:0] CH_9     = 8'd57;
    localparam logic [7:0] CH_LA    = 8'd97;
    localparam logic [7:0] CH_LF    = 8'd102;
    localparam logic [7:0] CH_UA    = 8'd65;
    localparam logic [7:0] CH_UF    = 8'd70;
    localparam logic [7:0] CH_LX    = 8'd120;
    localparam logic [7:0] CH_UX    = 8'd88;
    localparam logic [7:0] CH_LB    = 8'd98;
    localparam logic [7:0] CH_UB    = 8'd66;
    localparam logic [7:0] HEX_BASE = 8'd10;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_present;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic [OFF_W-1:0]        end_offset;
        logic                    found_number;
    } t_out;

    // classified character as handed from front to back
    typedef struct packed {
        logic       present;
        logic       last;
        logic       white;
        logic       sign;
        logic       minus;
        logic       dec;
        logic       zero;
        logic       hex;
        logic       bin;
        logic       x_pfx;
        logic       b_pfx;
        logic [3:0] digit;
    } t_tok;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [3:0] {
        PH_WHITE,
        PH_SIGNED,
        PH_ZERO,
        PH_DEC,
        PH_HEX_PFX,
        PH_HEX,
        PH_BIN_PFX,
        PH_BIN,
        PH_DONE_NUM,
        PH_DONE_NONE
    } t_phase;

endpackage

[hdl/ilp_front.sv]
module ilp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  ilp_pkg::t_in  i_item,
    input  logic          i_fifo_full,
    output logic          o_tok_valid,
    output ilp_pkg::t_tok o_tok
);

    logic          r_valid;
    ilp_pkg::t_tok r_tok;
    ilp_pkg::t_tok n_tok;
    logic          w_accept;
    logic          w_fwd;

    assign w_fwd       = r_valid && !i_fifo_full;
    assign full        = r_valid && i_fifo_full;
    assign w_accept    = push && !full;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    always_comb begin
        logic [7:0] c;
        c             = i_item.char_code;
        n_tok.present = i_item.char_present;
        n_tok.last    = i_item.is_last;
        n_tok.white   = (c == ilp_pkg::CH_SPACE) ||
                        (c >= ilp_pkg::CH_TAB && c <= ilp_pkg::CH_CR);
        n_tok.sign    = (c == ilp_pkg::CH_PLUS) || (c == ilp_pkg::CH_MINUS);
        n_tok.minus   = (c == ilp_pkg::CH_MINUS);
        n_tok.dec     = (c >= ilp_pkg::CH_0) && (c <= ilp_pkg::CH_9);
        n_tok.zero    = (c == ilp_pkg::CH_0);
        n_tok.bin     = (c == ilp_pkg::CH_0) || (c == ilp_pkg::CH_1);
        n_tok.x_pfx   = (c == ilp_pkg::CH_LX) || (c == ilp_pkg::CH_UX);
        n_tok.b_pfx   = (c == ilp_pkg::CH_LB) || (c == ilp_pkg::CH_UB);
        n_tok.hex     = n_tok.dec ||
                        (c >= ilp_pkg::CH_LA && c <= ilp_pkg::CH_LF) ||
                        (c >= ilp_pkg::CH_UA && c <= ilp_pkg::CH_UF);
        if (c >= ilp_pkg::CH_LA) begin
            n_tok.digit = 4'(c - ilp_pkg::CH_LA + ilp_pkg::HEX_BASE);
        end else if (c >= ilp_pkg::CH_UA) begin
            n_tok.digit = 4'(c - ilp_pkg::CH_UA + ilp_pkg::HEX_BASE);
        end else begin
            n_tok.digit = 4'(c - ilp_pkg::CH_0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (w_fwd) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tok <= n_tok;
        end
    end

endmodule

[hdl/ilp_fifo.sv]
module ilp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ilp_pkg::t_tok       i_tok,
    input  logic                i_pop,
    output ilp_pkg::t_tok       o_tok,
    output ilp_pkg::t_fifo_stat o_stat
);

    ilp_pkg::t_tok                      r_mem [ilp_pkg::FIFO_DEPTH];
    logic [ilp_pkg::FIFO_PTR_W-1:0]     r_wr_ptr;
    logic [ilp_pkg::FIFO_PTR_W-1:0]     r_rd_ptr;
    logic [ilp_pkg::FIFO_CNT_W-1:0]     r_count;
    logic                               w_wr;
    logic                               w_rd;

    localparam logic [ilp_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        ilp_pkg::FIFO_PTR_W'(ilp_pkg::FIFO_DEPTH - 1);
    localparam logic [ilp_pkg::FIFO_CNT_W-1:0] DEPTH_CNT =
        ilp_pkg::FIFO_CNT_W'(ilp_pkg::FIFO_DEPTH);

    assign o_stat.full  = (r_count == DEPTH_CNT);
    assign o_stat.empty = (r_count == '0);
    assign w_wr         = i_push && !o_stat.full;
    assign w_rd         = i_pop && !o_stat.empty;
    assign o_tok        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

[hdl/ilp_back.sv]
module ilp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tok_valid,
    input  ilp_pkg::t_tok i_tok,
    output logic          o_pop,
    input  logic          i_res_pop,
    output logic          o_res_valid,
    output ilp_pkg::t_out o_res
);

    localparam int VAL_W = ilp_pkg::VALUE_WIDTH;
    localparam int IDX_W = ilp_pkg::IDX_W;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(ilp_pkg::MAX_CHARS);

    ilp_pkg::t_phase  r_phase, n_phase;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic             r_neg, n_neg;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_end, n_end;
    logic             r_out_valid;
    ilp_pkg::t_out    r_out;
    ilp_pkg::t_out    w_res;
    logic             w_take;

    // a last token needs the result register free or leaving this cycle
    assign w_take      = i_tok_valid && (!i_tok.last || !r_out_valid || i_res_pop);
    assign o_pop       = w_take;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        ilp_pkg::t_phase  c_phase;
        logic [VAL_W-1:0] c_acc;
        logic             c_neg;
        logic [IDX_W-1:0] c_idx;
        logic [IDX_W-1:0] c_end;
        logic [IDX_W-1:0] next_index;
        logic [VAL_W-1:0] dv;
        logic [VAL_W-1:0] acc_dec;
        logic [VAL_W-1:0] acc_hex;
        logic [VAL_W-1:0] acc_bin;
        logic [VAL_W-1:0] v;
        logic             have;

        next_index = (r_idx < IDX_MAX) ? r_idx + 1'b1 : IDX_MAX;
        dv         = VAL_W'(i_tok.digit);
        acc_dec    = (r_acc << 3) + (r_acc << 1) + dv;
        acc_hex    = (r_acc << 4) | dv;
        acc_bin    = (r_acc << 1) | VAL_W'(i_tok.digit[0]);

        c_phase = r_phase;
        c_acc   = r_acc;
        c_neg   = r_neg;
        c_idx   = r_idx;
        c_end   = r_end;

        if (i_tok.present) begin
            c_idx = next_index;
            case (r_phase)
                ilp_pkg::PH_WHITE, ilp_pkg::PH_SIGNED: begin
                    if (r_phase == ilp_pkg::PH_WHITE && i_tok.white) begin
                        c_phase = r_phase;
                    end else if (r_phase == ilp_pkg::PH_WHITE && i_tok.sign) begin
                        c_neg   = i_tok.minus;
                        c_phase = ilp_pkg::PH_SIGNED;
                    end else if (i_tok.dec) begin
                        c_acc   = acc_dec;
                        c_end   = next_index;
                        c_phase = i_tok.zero ? ilp_pkg::PH_ZERO : ilp_pkg::PH_DEC;
                    end else begin
                        c_phase = ilp_pkg::PH_DONE_NONE;
                    end
                end
                ilp_pkg::PH_ZERO: begin
                    if (i_tok.x_pfx) begin
                        c_acc   = '0;
                        c_end   = '0;
                        c_phase = ilp_pkg::PH_HEX_PFX;
                    end else if (i_tok.b_pfx) begin
                        c_acc   = '0;
                        c_end   = '0;
                        c_phase = ilp_pkg::PH_BIN_PFX;
                    end else if (i_tok.dec) begin
                        c_acc   = acc_dec;
                        c_end   = next_index;
                        c_phase = ilp_pkg::PH_DEC;
                    end else begin
                        c_phase = ilp_pkg::PH_DONE_NUM;
                    end
                end
                ilp_pkg::PH_DEC: begin
                    if (i_tok.dec) begin
                        c_acc = acc_dec;
                        c_end = next_index;
                    end else begin
                        c_phase = ilp_pkg::PH_DONE_NUM;
                    end
                end
                ilp_pkg::PH_HEX_PFX, ilp_pkg::PH_HEX: begin
                    if (i_tok.hex) begin
                        c_acc   = acc_hex;
                        c_end   = next_index;
                        c_phase = ilp_pkg::PH_HEX;
                    end else begin
                        c_phase = (r_phase == ilp_pkg::PH_HEX) ?
                                  ilp_pkg::PH_DONE_NUM : ilp_pkg::PH_DONE_NONE;
                    end
                end
                ilp_pkg::PH_BIN_PFX, ilp_pkg::PH_BIN: begin
                    if (i_tok.bin) begin
                        c_acc   = acc_bin;
                        c_end   = next_index;
                        c_phase = ilp_pkg::PH_BIN;
                    end else begin
                        c_phase = (r_phase == ilp_pkg::PH_BIN) ?
                                  ilp_pkg::PH_DONE_NUM : ilp_pkg::PH_DONE_NONE;
                    end
                end
                default: begin
                    c_phase = r_phase;
                end
            endcase
        end

        case (c_phase)
            ilp_pkg::PH_ZERO, ilp_pkg::PH_DEC, ilp_pkg::PH_HEX,
            ilp_pkg::PH_BIN, ilp_pkg::PH_DONE_NUM: have = 1'b1;
            default:                               have = 1'b0;
        endcase

        v = c_neg ? (VAL_W'(0) - c_acc) : c_acc;
        if (have) begin
            w_res.value        = ilp_pkg::OUT_W'(signed'(v));
            w_res.end_offset   = ilp_pkg::OFF_W'(c_end);
            w_res.found_number = 1'b1;
        end else begin
            w_res.value        = '0;
            w_res.end_offset   = '0;
            w_res.found_number = 1'b0;
        end

        // string ends: back to the start state for the next one
        if (i_tok.last) begin
            n_phase = ilp_pkg::PH_WHITE;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_idx   = '0;
            n_end   = '0;
        end else begin
            n_phase = c_phase;
            n_acc   = c_acc;
            n_neg   = c_neg;
            n_idx   = c_idx;
            n_end   = c_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ilp_pkg::PH_WHITE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_idx       <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_idx   <= n_idx;
                r_end   <= n_end;
            end
            if (w_take && i_tok.last) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_tok.last) begin
            r_out <= w_res;
        end
    end

endmodule

[hdl/integer_literal_parser.sv]
// path: a last character passes the classify register and the token queue, then
// the parse state and the result register are written together
// throughput: one character per cycle, with a combinational shift-add in the parse
// unit; a full result register stalls a last character, and the queue fills behind it
// reset: synchronous active-low i_rst_n empties the queues and returns the
// parser to the leading-whitespace state
module integer_literal_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  ilp_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output ilp_pkg::t_out o_res
);

    logic                w_front_valid;
    ilp_pkg::t_tok       w_front_tok;
    ilp_pkg::t_tok       w_fifo_tok;
    ilp_pkg::t_fifo_stat w_fifo_stat;
    logic                w_fifo_pop;
    logic                w_res_valid;

    assign empty = !w_res_valid;

    ilp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_fifo_full (w_fifo_stat.full),
        .o_tok_valid (w_front_valid),
        .o_tok       (w_front_tok)
    );

    ilp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_tok   (w_front_tok),
        .i_pop   (w_fifo_pop),
        .o_tok   (w_fifo_tok),
        .o_stat  (w_fifo_stat)
    );

    ilp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!w_fifo_stat.empty),
        .i_tok       (w_fifo_tok),
        .o_pop       (w_fifo_pop),
        .i_res_pop   (pop && !empty),
        .o_res_valid (w_res_valid),
        .o_res       (o_res)
    );

    // an accepted transaction is held in the classify stage next cycle
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> w_front_valid)
        else $error("accepted character missing from classify stage");

    // the parser never reads an empty token queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_pop |-> !w_fifo_stat.empty)
        else $error("token queue read while empty");

    // a result appears only after a last token was parsed
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(w_fifo_pop && w_fifo_tok.last))
        else $error("result without a last character");

endmodule
